/* sv/rrss_pkg.sv */
// Shared types and constants of the round-robin slot scheduler.
`timescale 1ns / 1ps

package rrss_pkg;

  localparam int unsigned CtxW     = 64;
  localparam int unsigned RootW    = 44;
  localparam int unsigned IdW      = 16;
  localparam int unsigned ModeW    = 4;
  localparam int unsigned PadW     = CtxW - ModeW - RootW;

  // Number of task slots in the table and the width of a slot index.
  localparam int unsigned NumSlots = 4;
  localparam int unsigned SlotIdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // Translation mode placed in the top nibble of a space word.
  localparam logic [ModeW-1:0] SpaceMode = 4'h8;

  // Request codes.
  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqSpawn = 2'd1;
  localparam logic [1:0] ReqExit  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ResScheduled = 2'd0;
  localparam logic [1:0] ResSpawned   = 2'd1;
  localparam logic [1:0] ResFull      = 2'd2;

  typedef enum logic [1:0] {
    SlotUnused  = 2'd0,
    SlotReady   = 2'd1,
    SlotRunning = 2'd2
  } slot_st_e;

endpackage

/* sv/round_robin_slot_scheduler.sv */
// Round-robin task slot scheduler: slot table, sequencer and result register.
`timescale 1ns / 1ps

// The block keeps NumSlots task slots, each with a status held in flip-flops and a
// saved context, root page number and task id held in small memories. A single
// compare unit walks the slots one per cycle under a sequencer, so the block
// handles one request at a time and drops in_ready_o while it works. A spawn
// scans slots from slot 0 in StSpawn until it finds an unused one (at most
// NumSlots), then hands the result to the output register in StPush. A tick or
// an exit saves or frees the current slot in StPrep, visits slots in the
// round-robin search in StSearch (at most NumSlots), takes the registered memory
// read in StLoad and hands off the result in StPush; when nothing is ready and
// there is no current task StLoad is skipped. The finished result sits in its
// own output register, so a new request may be transferred while the previous
// result still waits for out_ready_i. Reset marks every slot unused, sets the
// next id to one and clears the current task; no clearing pass is needed
// because a slot's memories are always written by a spawn before their read
// data is used.
module round_robin_slot_scheduler
  import rrss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          req_type_i,
  input  logic [CtxW-1:0]     context_handle_i,
  input  logic [RootW-1:0]    root_page_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [SlotIdxW-1:0] slot_index_o,
  output logic [CtxW-1:0]     resume_context_o,
  output logic                switched_o,
  output logic [CtxW-1:0]     space_word_o,
  output logic [IdW-1:0]      task_id_o
);

  localparam int unsigned IdxW = SlotIdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumSlots - 1);
  localparam logic [IdxW-1:0] FirstAfterZero = IdxW'(1);

  typedef enum logic [2:0] {
    StIdle,
    StSpawn,
    StPrep,
    StSearch,
    StLoad,
    StPush
  } state_e;

  state_e state_q;

  // Latched request.
  logic [1:0]       req_q;
  logic [CtxW-1:0]  ctx_q;
  logic [RootW-1:0] root_q;

  // Slot table control state.
  slot_st_e         slot_st_q [NumSlots];
  logic [IdW-1:0]   next_id_q;
  logic             cur_valid_q;
  logic [IdxW-1:0]  cur_slot_q;

  // Walk position and visit count.
  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  cnt_q;

  // Result staging, handed to the output register when it is free.
  logic [1:0]       res_status_q;
  logic [IdxW-1:0]  res_slot_q;
  logic [CtxW-1:0]  res_ctx_q;
  logic             res_sw_q;
  logic [CtxW-1:0]  res_space_q;
  logic [IdW-1:0]   res_id_q;

  // Slot memories and their registered read data.
  logic [CtxW-1:0]  ctx_mem  [NumSlots];
  logic [RootW-1:0] root_mem [NumSlots];
  logic [IdW-1:0]   id_mem   [NumSlots];
  logic [CtxW-1:0]  rd_ctx_q;
  logic [RootW-1:0] rd_root_q;
  logic [IdW-1:0]   rd_id_q;

  logic             ctx_we;
  logic             spawn_we;
  logic [IdxW-1:0]  mem_waddr;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;

  logic [IdxW-1:0]  idx_inc;
  logic [IdxW-1:0]  cur_inc;
  slot_st_e         idx_st;
  slot_st_e         cur_st;
  logic             out_free;

  assign in_ready_o = (state_q == StIdle);
  assign out_free   = !out_valid_o || out_ready_i;

  assign idx_inc = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  assign cur_inc = (cur_slot_q == LastIdx) ? '0 : cur_slot_q + 1'b1;
  assign idx_st  = slot_st_q[idx_q];
  assign cur_st  = slot_st_q[cur_slot_q];

  // Memory port control. The context is saved when the running task is
  // interrupted; a spawn writes all three memories of the slot it takes.
  always_comb begin
    ctx_we    = 1'b0;
    spawn_we  = 1'b0;
    mem_waddr = idx_q;
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    case (state_q)
      StSpawn: begin
        spawn_we = (idx_st == SlotUnused);
        ctx_we   = (idx_st == SlotUnused);
      end
      StPrep: begin
        mem_waddr = cur_slot_q;
        ctx_we    = !(req_q == ReqExit && cur_valid_q) && cur_valid_q &&
                    (cur_st == SlotRunning);
      end
      StSearch: begin
        mem_re    = 1'b1;
        mem_raddr = (idx_st == SlotReady) ? idx_q : cur_slot_q;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctx_we) begin
      ctx_mem[mem_waddr] <= ctx_q;
    end
    if (spawn_we) begin
      root_mem[mem_waddr] <= root_q;
      id_mem[mem_waddr]   <= next_id_q;
    end
    if (mem_re) begin
      rd_ctx_q  <= ctx_mem[mem_raddr];
      rd_root_q <= root_mem[mem_raddr];
      rd_id_q   <= id_mem[mem_raddr];
    end
  end

  // Sequencer, slot status and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      req_q        <= ReqTick;
      ctx_q        <= '0;
      root_q       <= '0;
      for (int unsigned i = 0; i < NumSlots; i++) begin
        slot_st_q[i] <= SlotUnused;
      end
      next_id_q        <= IdW'(1);
      cur_valid_q      <= 1'b0;
      cur_slot_q       <= '0;
      idx_q            <= '0;
      cnt_q            <= '0;
      res_status_q     <= ResScheduled;
      res_slot_q       <= '0;
      res_ctx_q        <= '0;
      res_sw_q         <= 1'b0;
      res_space_q      <= '0;
      res_id_q         <= '0;
      out_valid_o      <= 1'b0;
      status_o         <= ResScheduled;
      slot_index_o     <= '0;
      resume_context_o <= '0;
      switched_o       <= 1'b0;
      space_word_o     <= '0;
      task_id_o        <= '0;
    end else begin
      // In the hand-off state the output register is refilled below instead.
      if (out_valid_o && out_ready_i && state_q != StPush) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            req_q   <= req_type_i;
            ctx_q   <= context_handle_i;
            root_q  <= root_page_i;
            idx_q   <= '0;
            cnt_q   <= '0;
            state_q <= (req_type_i == ReqSpawn) ? StSpawn : StPrep;
          end
        end
        StSpawn: begin
          if (idx_st == SlotUnused) begin
            slot_st_q[idx_q] <= SlotReady;
            res_status_q     <= ResSpawned;
            res_slot_q       <= idx_q;
            res_ctx_q        <= '0;
            res_sw_q         <= 1'b0;
            res_space_q      <= '0;
            res_id_q         <= next_id_q;
            next_id_q        <= next_id_q + 1'b1;
            state_q          <= StPush;
          end else if (idx_q == LastIdx) begin
            res_status_q <= ResFull;
            res_slot_q   <= '0;
            res_ctx_q    <= '0;
            res_sw_q     <= 1'b0;
            res_space_q  <= '0;
            res_id_q     <= '0;
            state_q      <= StPush;
          end else begin
            idx_q <= idx_inc;
          end
        end
        StPrep: begin
          cnt_q   <= '0;
          state_q <= StSearch;
          if (req_q == ReqExit && cur_valid_q) begin
            // The exiting task gives up its slot; the search starts after slot 0.
            slot_st_q[cur_slot_q] <= SlotUnused;
            cur_valid_q           <= 1'b0;
            cur_slot_q            <= '0;
            idx_q                 <= FirstAfterZero;
          end else begin
            if (cur_valid_q && cur_st == SlotRunning) begin
              slot_st_q[cur_slot_q] <= SlotReady;
            end
            idx_q <= cur_valid_q ? cur_inc : FirstAfterZero;
          end
        end
        StSearch: begin
          if (idx_st == SlotReady) begin
            cur_valid_q      <= 1'b1;
            cur_slot_q       <= idx_q;
            slot_st_q[idx_q] <= SlotRunning;
            res_sw_q         <= 1'b1;
            res_slot_q       <= idx_q;
            state_q          <= StLoad;
          end else if (cnt_q == LastIdx) begin
            if (cur_valid_q) begin
              // Nothing else is ready: the current task keeps running.
              slot_st_q[cur_slot_q] <= SlotRunning;
              res_sw_q              <= 1'b0;
              res_slot_q            <= cur_slot_q;
              state_q               <= StLoad;
            end else begin
              // No task at all: hand the incoming context straight back.
              res_status_q <= ResScheduled;
              res_slot_q   <= '0;
              res_ctx_q    <= ctx_q;
              res_sw_q     <= 1'b0;
              res_space_q  <= '0;
              res_id_q     <= '0;
              state_q      <= StPush;
            end
          end else begin
            idx_q <= idx_inc;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StLoad: begin
          res_status_q <= ResScheduled;
          res_ctx_q    <= rd_ctx_q;
          res_space_q  <= res_sw_q ? {SpaceMode, {PadW{1'b0}}, rd_root_q} : '0;
          res_id_q     <= rd_id_q;
          state_q      <= StPush;
        end
        StPush: begin
          if (out_free) begin
            out_valid_o      <= 1'b1;
            status_o         <= res_status_q;
            slot_index_o     <= SlotIdxW'(res_slot_q);
            resume_context_o <= res_ctx_q;
            switched_o       <= res_sw_q;
            space_word_o     <= res_space_q;
            task_id_o        <= res_id_q;
            state_q          <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

/* sv/rrss_checker.sv */
// Port-level checker for the round-robin slot scheduler and its bind.
`timescale 1ns / 1ps

module rrss_checker
  import rrss_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [1:0]          status_o,
  input logic [SlotIdxW-1:0] slot_index_o,
  input logic [CtxW-1:0]     resume_context_o,
  input logic                switched_o,
  input logic [CtxW-1:0]     space_word_o,
  input logic [IdW-1:0]      task_id_o
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // After a transfer in, the block is busy with that request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high right after a transfer");

  // A refused spawn reports nothing else.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ResFull |->
      slot_index_o == '0 && resume_context_o == '0 && !switched_o &&
      task_id_o == '0)
    else $error("refused spawn carries data");

  // A switch only comes from a schedule and carries a translation mode.
  a_switch_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && switched_o |->
      status_o == ResScheduled && space_word_o[CtxW-1 -: ModeW] == SpaceMode)
    else $error("switch without schedule or mode");

  // Without a switch the space word is zero.
  a_space_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !switched_o |-> space_word_o == '0)
    else $error("space word set without a switch");

endmodule

bind round_robin_slot_scheduler rrss_checker u_rrss_checker (.*);

/* verif/round_robin_slot_scheduler_tb.sv */
// Self-checking testbench for the round-robin task slot scheduler.
`timescale 1ns / 1ps

module round_robin_slot_scheduler_tb;
  import rrss_pkg::*;

  localparam int unsigned Slots      = NumSlots;
  localparam int unsigned LongHold   = 200;
  localparam int unsigned DrainWait  = Slots + 8;
  localparam int unsigned DrainMax   = 4000;
  localparam int unsigned MaxShown   = 50;
  localparam int unsigned RandItems  = 800;
  localparam int unsigned TailRounds = 40;

  // Request code three is not named in the package; the block treats it as a tick.
  localparam logic [1:0] ReqAliasTick = 2'd3;

  typedef struct packed {
    logic [1:0]          status;
    logic [SlotIdxW-1:0] slot;
    logic [CtxW-1:0]     resume;
    logic                sw;
    logic [CtxW-1:0]     space;
    logic [IdW-1:0]      id;
  } sched_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          req_type_i;
  logic [CtxW-1:0]     context_handle_i;
  logic [RootW-1:0]    root_page_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          status_o;
  logic [SlotIdxW-1:0] slot_index_o;
  logic [CtxW-1:0]     resume_context_o;
  logic                switched_o;
  logic [CtxW-1:0]     space_word_o;
  logic [IdW-1:0]      task_id_o;

  round_robin_slot_scheduler u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .context_handle_i(context_handle_i),
    .root_page_i     (root_page_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .resume_context_o(resume_context_o),
    .switched_o      (switched_o),
    .space_word_o    (space_word_o),
    .task_id_o       (task_id_o)
  );

  // Shadow copy of the slot table, advanced at each accepted request.
  slot_st_e       tbl_st    [Slots];
  logic [CtxW-1:0] tbl_ctx  [Slots];
  logic [CtxW-1:0] tbl_space[Slots];
  logic [IdW-1:0]  tbl_id   [Slots];
  logic [IdW-1:0]  next_tid;
  bit              cur_valid;
  int unsigned     cur_slot;

  sched_res_t sched_q[$];

  bit          idle_en;
  int unsigned hold_reqs;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned stall_left;

  int unsigned n_err;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_switch;
  int unsigned n_spawned;
  int unsigned n_full;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #(60_000_000);
    $display("round_robin_slot_scheduler: mismatch");
    $finish;
  end

  function automatic void table_reset();
    int i;
    for (i = 0; i < Slots; i++) begin
      tbl_st[i]    = SlotUnused;
      tbl_ctx[i]   = '0;
      tbl_space[i] = '0;
      tbl_id[i]    = '0;
    end
    next_tid  = 16'd1;
    cur_valid = 1'b0;
    cur_slot  = 0;
  endfunction

  function automatic int unsigned slots_in_use();
    int i;
    int unsigned n;
    n = 0;
    for (i = 0; i < Slots; i++) begin
      if (tbl_st[i] != SlotUnused) n++;
    end
    return n;
  endfunction

  // Works out the result of one request and moves the shadow table on.
  function automatic sched_res_t predict_request(input logic [1:0] rt,
                                                 input logic [CtxW-1:0] ctx,
                                                 input logic [RootW-1:0] root);
    sched_res_t r;
    int i;
    int unsigned idx;
    bit hit;
    r   = '0;
    hit = 1'b0;
    if (rt == ReqSpawn) begin
      // The lowest unused slot takes the new task.
      for (i = 0; i < Slots; i++) begin
        if (!hit && tbl_st[i] == SlotUnused) begin
          hit          = 1'b1;
          tbl_id[i]    = next_tid;
          next_tid     = next_tid + 16'd1;
          tbl_space[i] = {SpaceMode, {PadW{1'b0}}, root};
          tbl_ctx[i]   = ctx;
          tbl_st[i]    = SlotReady;
          r.status     = ResSpawned;
          r.slot       = i[SlotIdxW-1:0];
          r.id         = tbl_id[i];
        end
      end
      if (!hit) r.status = ResFull;
      return r;
    end
    if (rt == ReqExit && cur_valid) begin
      tbl_st[cur_slot] = SlotUnused;
      cur_valid        = 1'b0;
      cur_slot         = 0;
    end
    if (cur_valid && tbl_st[cur_slot] == SlotRunning) begin
      tbl_ctx[cur_slot] = ctx;
      tbl_st[cur_slot]  = SlotReady;
    end
    // The search starts one past the current slot, or at slot 1 with no current task.
    idx = cur_valid ? (cur_slot + 1) % Slots : 1 % Slots;
    for (i = 0; i < Slots; i++) begin
      if (!hit) begin
        if (tbl_st[idx] == SlotReady) hit = 1'b1;
        else idx = (idx + 1) % Slots;
      end
    end
    r.status = ResScheduled;
    if (hit) begin
      cur_valid    = 1'b1;
      cur_slot     = idx;
      tbl_st[idx]  = SlotRunning;
      r.slot       = idx[SlotIdxW-1:0];
      r.resume     = tbl_ctx[idx];
      r.sw         = 1'b1;
      r.space      = tbl_space[idx];
      r.id         = tbl_id[idx];
    end else if (cur_valid) begin
      tbl_st[cur_slot] = SlotRunning;
      r.slot           = cur_slot[SlotIdxW-1:0];
      r.resume         = tbl_ctx[cur_slot];
      r.id             = tbl_id[cur_slot];
    end else begin
      r.resume = ctx;
    end
    return r;
  endfunction

  function automatic logic [CtxW-1:0] rand_ctx();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [RootW-1:0] rand_root();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return raw[RootW-1:0];
    endcase
  endfunction

  // Offers one request, waits for its transfer and records the expected result.
  // Valid stays high afterwards so that back-to-back requests need no gap.
  task automatic send_req(input logic [1:0] rt, input logic [CtxW-1:0] ctx,
                          input logic [RootW-1:0] root);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= rt;
    context_handle_i <= ctx;
    root_page_i      <= root;
    do @(posedge clk_i); while (!in_ready_o);
    sched_q.push_back(predict_request(rt, ctx, root));
    n_sent++;
  endtask

  // Lowers valid and waits until every expected result has been seen.
  task automatic wait_drain();
    int unsigned n;
    in_valid_i <= 1'b0;
    n = 0;
    while (sched_q.size() != 0 && n < DrainMax) begin
      @(posedge clk_i);
      n++;
    end
    if (sched_q.size() != 0) begin
      $error("%0d expected results never arrived", sched_q.size());
      n_err++;
      sched_q.delete();
    end
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic cmp_field(input string name, input logic [63:0] want,
                           input logic [63:0] got);
    if (want !== got) begin
      if (n_err < MaxShown) $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_err++;
    end
  endtask

  // Result side: checks each transfer, then picks the ready level for the next cycle.
  always @(posedge clk_i) begin : result_side
    sched_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (sched_q.size() == 0) begin
          $error("result with no request outstanding");
          n_err++;
        end else begin
          want = sched_q.pop_front();
          cmp_field("status", 64'(want.status), 64'(status_o));
          cmp_field("slot_index", 64'(want.slot), 64'(slot_index_o));
          cmp_field("resume_context", want.resume, resume_context_o);
          cmp_field("switched", 64'(want.sw), 64'(switched_o));
          cmp_field("space_word", want.space, space_word_o);
          cmp_field("task_id", 64'(want.id), 64'(task_id_o));
          n_checked++;
          if (want.sw) n_switch++;
          if (want.status == ResSpawned) n_spawned++;
          if (want.status == ResFull) n_full++;
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end else begin
      out_ready_i <= 1'b0;
    end
  end

  // Empty table: schedules echo the incoming context, exits act as ticks.
  task automatic test_empty_table();
    send_req(ReqTick, '1, '1);
    send_req(ReqTick, '0, '0);
    send_req(ReqExit, 64'h0123_4567_89ab_cdef, '0);
    send_req(ReqAliasTick, 64'hfedc_ba98_7654_3210, '1);
    wait_drain();
  endtask

  // Fills every slot with extreme root pages, then one spawn too many.
  task automatic test_fill_table();
    send_req(ReqSpawn, '1, '1);
    send_req(ReqSpawn, '0, '0);
    send_req(ReqSpawn, 64'h8000_0000_0000_0001, 44'h800_0000_0001);
    send_req(ReqSpawn, 64'h5555_aaaa_5555_aaaa, 44'h555_aaaa_5555);
    send_req(ReqSpawn, 64'h1, 44'h1);
    wait_drain();
  endtask

  // Ticks rotate through the full table; exits free slots until none is left.
  task automatic test_rotation();
    int i;
    for (i = 0; i < 5; i++) send_req(ReqTick, {$urandom, $urandom}, '0);
    send_req(ReqAliasTick, '1, '0);
    send_req(ReqExit, '0, '0);
    send_req(ReqSpawn, 64'hc0de, 44'hfff_0000_ffff);
    for (i = 0; i < 5; i++) send_req(ReqExit, {$urandom, $urandom}, '0);
    send_req(ReqTick, '1, '0);
    wait_drain();
  endtask

  // A lone task is chosen on every tick, and is interrupted by each tick after the first.
  task automatic test_lone_task();
    send_req(ReqSpawn, 64'h1111, 44'h222);
    send_req(ReqTick, 64'h3333, '0);
    send_req(ReqTick, 64'h4444, '0);
    send_req(ReqExit, 64'h5555, '0);
    wait_drain();
  endtask

  // The result side holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    int i;
    hold_reqs++;
    for (i = 0; i < 12; i++) begin
      case (i % 3)
        0:       send_req(ReqSpawn, rand_ctx(), rand_root());
        1:       send_req(ReqTick, rand_ctx(), rand_root());
        default: send_req(ReqExit, rand_ctx(), rand_root());
      endcase
    end
    wait_drain();
  endtask

  // Random mix, biased so that the table keeps turning over.
  task automatic test_random_mix();
    int i;
    int unsigned pick;
    logic [1:0] rt;
    for (i = 0; i < RandItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) rt = ReqTick;
      else if (pick < 65) rt = ReqSpawn;
      else if (pick < 92) rt = ReqExit;
      else rt = ReqAliasTick;
      if (rt == ReqSpawn && slots_in_use() == Slots && $urandom_range(0, 3) != 0) rt = ReqExit;
      send_req(rt, rand_ctx(), rand_root());
      if (i % 300 == 299) wait_drain();
    end
    wait_drain();
  endtask

  // Closing stretch with idling off: a full table turns over through exits,
  // spawns and ticks sent back to back.
  task automatic test_no_idle_tail();
    int i;
    idle_en = 1'b0;
    while (slots_in_use() < Slots) send_req(ReqSpawn, rand_ctx(), rand_root());
    for (i = 0; i < TailRounds; i++) begin
      send_req(ReqExit, rand_ctx(), rand_root());
      send_req(ReqSpawn, rand_ctx(), rand_root());
      send_req(ReqTick, rand_ctx(), rand_root());
    end
    send_req(ReqSpawn, rand_ctx(), rand_root());
    send_req(ReqTick, rand_ctx(), rand_root());
    wait_drain();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    req_type_i       <= ReqTick;
    context_handle_i <= '0;
    root_page_i      <= '0;
    idle_en    = 1'b1;
    hold_reqs  = 0;
    hold_seen  = 0;
    hold_left  = 0;
    stall_left = 0;
    n_err      = 0;
    n_sent     = 0;
    n_checked  = 0;
    n_switch   = 0;
    n_spawned  = 0;
    n_full     = 0;
    table_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_fill_table();
    test_rotation();
    test_lone_task();
    test_backpressure();
    test_random_mix();
    test_no_idle_tail();

    $display("Sent %0d requests and checked %0d results: %0d task switches,",
             n_sent, n_checked, n_switch);
    $display("%0d spawns, %0d refused on a full table, plus a long result stall.",
             n_spawned, n_full);
    if (n_err == 0) begin
      $display("round_robin_slot_scheduler: match");
    end else begin
      $display("round_robin_slot_scheduler: mismatch");
    end
    $finish;
  end

endmodule
